/* design/catt_pkg.sv */
// Package for the comma-aware text tokenizer: result kinds, lexer modes,
// queue entry layout and sizing constants.
// No dependencies; every other file of the block but catt_if.sv imports it.
`default_nettype none

package catt_pkg;

	// Longest token kept is MAX_TOKEN-1 bytes
	localparam int MAX_TOKEN = 1024;
	localparam int KEPT_W    = $clog2(MAX_TOKEN);
	localparam logic [KEPT_W-1:0] KEPT_MAX = KEPT_W'(MAX_TOKEN - 1);

	// Decoupling queue between lexer and result sequencer
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Results one text byte can cause at most
	localparam int MAX_RES = 3;

	// Character constants
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_END_TOKEN = 2'd1,
		KIND_END_TEXT  = 2'd2
	} kind_t;

	typedef enum logic [6:0] {
		MODE_SKIP       = 7'b0000001,
		MODE_SLASH      = 7'b0000010,
		MODE_LINE       = 7'b0000100,
		MODE_BLOCK      = 7'b0001000,
		MODE_BLOCK_STAR = 7'b0010000,
		MODE_QUOTED     = 7'b0100000,
		MODE_WORD       = 7'b1000000
	} mode_t;

	// One result as it leaves the block
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} res_t;

	// All results of one text byte; cnt is 1..MAX_RES
	typedef struct packed {
		logic [1:0]            cnt;
		res_t [MAX_RES-1:0]    res;
	} entry_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

/* design/catt_if.sv */
// Valid/ready channel interfaces of the tokenizer: text byte in, result out.
// Does not use catt_pkg; the result kind is a plain two-bit field.
`default_nettype none

interface catt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink   (input valid, input text_byte, output ready);
endinterface

interface catt_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] token_byte;
	logic       last;

	modport source (output valid, output out_kind, output token_byte, output last, input ready);
	modport sink   (input valid, input out_kind, input token_byte, input last, output ready);
endinterface

`default_nettype wire

/* design/catt_front.sv */
// Lexer front end: accepts text bytes, tracks lexer mode and kept length,
// and packs the results of each byte into one queue entry. Uses catt_pkg.
`default_nettype none

module catt_front
	import catt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	catt_byte_if.sink    in_ch,
	input  wire q_stat_t stat,
	output logic         push,
	output entry_t       push_data
);

	mode_t             mode_q, nxt_mode;
	logic [KEPT_W-1:0] kept_q, nxt_kept;
	entry_t            ent;
	logic              do_word;
	logic [7:0]        c;
	logic              fire;

	// Append one result to an entry
	function automatic entry_t add_res(entry_t e, kind_t k, logic [7:0] b);
		e.res[e.cnt].kind = k;
		e.res[e.cnt].data = (k == KIND_BYTE) ? b : 8'h00;
		e.cnt = e.cnt + 2'd1;
		return e;
	endfunction

	assign c           = in_ch.text_byte;
	assign in_ch.ready = !stat.full;
	assign fire        = in_ch.valid && in_ch.ready;

	// Next mode and results for the current byte
	always_comb begin
		nxt_mode = mode_q;
		nxt_kept = kept_q;
		ent      = '0;
		do_word  = 1'b0;
		case (mode_q)
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					nxt_mode = MODE_LINE;
				end else if (c == CH_STAR) begin
					nxt_mode = MODE_BLOCK_STAR;
				end else begin
					// lone slash opens a word; kept length restarts at one
					nxt_kept = KEPT_W'(1);
					ent      = add_res(ent, KIND_BYTE, CH_SLASH);
					do_word  = 1'b1;
				end
			end
			MODE_LINE: begin
				if (c == CH_NUL) begin
					ent      = add_res(ent, KIND_END_TEXT, 8'h00);
					nxt_mode = MODE_SKIP;
				end else if (c == CH_LF) begin
					nxt_mode = MODE_SKIP;
				end
			end
			MODE_BLOCK, MODE_BLOCK_STAR: begin
				if (c == CH_NUL) begin
					ent      = add_res(ent, KIND_END_TEXT, 8'h00);
					nxt_mode = MODE_SKIP;
				end else if (c == CH_STAR) begin
					nxt_mode = MODE_BLOCK_STAR;
				end else if (c == CH_SLASH && mode_q == MODE_BLOCK_STAR) begin
					nxt_mode = MODE_SKIP;
				end else begin
					nxt_mode = MODE_BLOCK;
				end
			end
			MODE_QUOTED: begin
				if (c == CH_NUL) begin
					ent      = add_res(ent, KIND_END_TOKEN, 8'h00);
					ent      = add_res(ent, KIND_END_TEXT, 8'h00);
					nxt_mode = MODE_SKIP;
					nxt_kept = '0;
				end else if (c == CH_QUOTE) begin
					ent      = add_res(ent, KIND_END_TOKEN, 8'h00);
					nxt_mode = MODE_SKIP;
					nxt_kept = '0;
				end else if (kept_q < KEPT_MAX) begin
					nxt_kept = kept_q + 1'b1;
					ent      = add_res(ent, KIND_BYTE, c);
				end
			end
			MODE_WORD: begin
				do_word = 1'b1;
			end
			default: begin
				// between tokens; unused codes behave the same
				nxt_kept = '0;
				if (c == CH_NUL) begin
					ent      = add_res(ent, KIND_END_TEXT, 8'h00);
					nxt_mode = MODE_SKIP;
				end else if (c <= CH_SPACE) begin
					nxt_mode = MODE_SKIP;
				end else if (c == CH_SLASH) begin
					nxt_mode = MODE_SLASH;
				end else if (c == CH_QUOTE) begin
					nxt_mode = MODE_QUOTED;
				end else begin
					nxt_kept = KEPT_W'(1);
					ent      = add_res(ent, KIND_BYTE, c);
					nxt_mode = MODE_WORD;
				end
			end
		endcase

		// Byte inside an open word
		if (do_word) begin
			if (c == CH_NUL) begin
				ent      = add_res(ent, KIND_END_TOKEN, 8'h00);
				ent      = add_res(ent, KIND_END_TEXT, 8'h00);
				nxt_mode = MODE_SKIP;
				nxt_kept = '0;
			end else if (c <= CH_SPACE) begin
				ent      = add_res(ent, KIND_END_TOKEN, 8'h00);
				nxt_mode = MODE_SKIP;
				nxt_kept = '0;
			end else if (c == CH_COMMA) begin
				// comma ends the word and opens the next one
				ent      = add_res(ent, KIND_END_TOKEN, 8'h00);
				ent      = add_res(ent, KIND_BYTE, c);
				nxt_kept = KEPT_W'(1);
				nxt_mode = MODE_WORD;
			end else begin
				if (nxt_kept < KEPT_MAX) begin
					nxt_kept = nxt_kept + 1'b1;
					ent      = add_res(ent, KIND_BYTE, c);
				end
				nxt_mode = MODE_WORD;
			end
		end
	end

	// Only bytes that cause results take a queue slot
	assign push      = fire && (ent.cnt != 2'd0);
	assign push_data = ent;

	// Lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP;
			kept_q <= '0;
		end else if (fire) begin
			mode_q <= nxt_mode;
			kept_q <= nxt_kept;
		end
	end

endmodule

`default_nettype wire

/* design/catt_fifo.sv */
// Short queue of result groups between lexer and result sequencer.
// Register-based, head shown combinationally. Uses catt_pkg.
`default_nettype none

module catt_fifo
	import catt_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_data,
	input  wire logic   pop,
	output entry_t      head,
	output q_stat_t     stat
);

	entry_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;

	assign stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/catt_back.sv */
// Result sequencer: walks the results of the queue head one per cycle into
// the output register unless it stalls, and marks the last. Uses catt_pkg.
`default_nettype none

module catt_back
	import catt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire entry_t  head,
	input  wire q_stat_t stat,
	output logic         pop,
	catt_res_if.source   out_ch
);

	logic [1:0] idx_q;
	logic       load;
	logic       at_end;
	logic       valid_q;
	kind_t      kind_q;
	logic [7:0] data_q;
	logic       last_q;

	assign load   = !stat.empty && (!valid_q || out_ch.ready);
	assign at_end = (idx_q == head.cnt - 2'd1);
	assign pop    = load && at_end;

	assign out_ch.valid      = valid_q;
	assign out_ch.out_kind   = kind_q;
	assign out_ch.token_byte = data_q;
	assign out_ch.last       = last_q;

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= head.res[idx_q].kind;
			data_q <= head.res[idx_q].data;
			last_q <= at_end;
		end
	end

	// Output valid and result index within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/comma_aware_text_tokenizer_top.sv */
// A text byte's results go into the queue and then, one at a time, into the
//   output register, which drives the result channel.
// Throughput, while the output is not stalled: one text byte per cycle as
//   long as bytes cause at most one result; the output register passes one
//   result per cycle, so a byte with two or three results holds it for each
//   in turn, buffered by a four-entry queue between lexer and sequencer.
// Reset (arst_n low): lexer between tokens, kept length zero, queue empty.
`default_nettype none

module comma_aware_text_tokenizer_top
	import catt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	catt_byte_if.sink  in_ch,
	catt_res_if.source out_ch
);

	logic    push;
	logic    pop;
	entry_t  push_data;
	entry_t  head;
	q_stat_t stat;

	// Lexer front end
	catt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.stat      (stat),
		.push      (push),
		.push_data (push_data)
	);

	// Decoupling queue
	catt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	// Result sequencer
	catt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

/* design/catt_checker.sv */
// Port-level checks of the tokenizer output, bound to the top level.
// Depends on catt_pkg for the result kind codes.
`default_nettype none

module catt_checker
	import catt_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] out_kind,
	input wire logic [7:0] token_byte,
	input wire logic       last
);

	// A stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind)
			&& $stable(token_byte) && $stable(last))
		else $error("stalled result changed");

	// Only token bytes carry data
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind != KIND_BYTE) |-> token_byte == 8'h00)
		else $error("non-byte result with data");

	// End of text is always the final result of its byte
	a_eot_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_END_TEXT) |-> last)
		else $error("end of text not marked last");

endmodule

bind comma_aware_text_tokenizer_top catt_checker u_catt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_kind   (out_ch.out_kind),
	.token_byte (out_ch.token_byte),
	.last       (out_ch.last)
);

`default_nettype wire

/* verif/comma_aware_text_tokenizer_top_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for comma_aware_text_tokenizer_top: directed and random text bytes,
// with a built-in lexer that predicts every result and its last flag.
// Depends on catt_pkg, catt_if.sv and the tokenizer RTL.

module comma_aware_text_tokenizer_top_test;
	import catt_pkg::*;

	localparam int RANDOM_ITEMS = 450;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	// Directed text: skipped controls, high bytes with a comma split, lone slashes,
	// empty and unterminated quotes, bare end of text, a block and a line comment
	localparam logic [7:0] DIRECTED [0:24] = '{
		8'h20, 8'h01,
		8'h80, 8'hFF, CH_COMMA, 8'h78, CH_SPACE,
		CH_SLASH, 8'h71, CH_NUL,
		CH_SLASH, CH_NUL,
		CH_QUOTE, CH_QUOTE,
		CH_QUOTE, 8'h41, CH_NUL,
		CH_NUL,
		CH_SLASH, CH_STAR, CH_SLASH,
		CH_SLASH, CH_SLASH, 8'h7A, CH_LF
	};

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} tok_res_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	catt_byte_if text_ch ();
	catt_res_if  tok_ch ();

	comma_aware_text_tokenizer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (text_ch.sink),
		.out_ch (tok_ch.source)
	);

	// Bench-side drivers, known from time zero
	logic       send_valid = 1'b0;
	logic [7:0] send_byte  = '0;
	logic       res_ready  = 1'b0;

	assign text_ch.valid     = send_valid;
	assign text_ch.text_byte = send_byte;
	assign tok_ch.ready      = res_ready;

	logic [7:0] text_q [$];
	tok_res_t   tok_expect_q [$];
	int         total_bytes = 1;
	int         bytes_done  = 0;
	int         mismatches  = 0;
	int         idle_cycles = 0;

	// Lexer state of the predictor
	mode_t             lex_mode = MODE_SKIP;
	logic [KEPT_W-1:0] kept_len = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// Idle percentage per side: sender 26 / receiver 75, then swapped, then none
	function automatic int idle_pct(input bit receiver);
		int stage;
		stage = (bytes_done * 3) / total_bytes;
		case (stage)
			0: return receiver ? 75 : 26;
			1: return receiver ? 26 : 75;
			default: return 0;
		endcase
	endfunction

	function automatic logic [7:0] rand_word_char();
		logic [7:0] c;
		c = 8'($urandom_range(33, 255));
		if (c == CH_COMMA)
			c = 8'h2D;
		return c;
	endfunction

	// First byte of a word must not open a comment or a quote
	function automatic logic [7:0] rand_word_start();
		logic [7:0] c;
		c = rand_word_char();
		if (c == CH_SLASH || c == CH_QUOTE)
			c = 8'h77;
		return c;
	endfunction

	task automatic push_res(input kind_t k, input logic [7:0] d);
		tok_expect_q.push_back('{kind: k, data: (k == KIND_BYTE) ? d : 8'h00, last: 1'b0});
	endtask

	// Token byte, dropped once the kept length is saturated
	task automatic keep_byte(input logic [7:0] c);
		if (kept_len < KEPT_MAX) begin
			kept_len++;
			push_res(KIND_BYTE, c);
		end
	endtask

	// Byte arriving while a word is open
	task automatic word_step(input logic [7:0] c);
		if (c == CH_NUL) begin
			push_res(KIND_END_TOKEN, '0);
			push_res(KIND_END_TEXT, '0);
			lex_mode = MODE_SKIP;
			kept_len = '0;
		end else if (c <= CH_SPACE) begin
			push_res(KIND_END_TOKEN, '0);
			lex_mode = MODE_SKIP;
			kept_len = '0;
		end else if (c == CH_COMMA) begin
			push_res(KIND_END_TOKEN, '0);
			kept_len = '0;
			keep_byte(c);
			lex_mode = MODE_WORD;
		end else begin
			keep_byte(c);
			lex_mode = MODE_WORD;
		end
	endtask

	// Predict the results of one transferred text byte
	task automatic lex_byte(input logic [7:0] c);
		int first;
		first = tok_expect_q.size();
		case (lex_mode)
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					lex_mode = MODE_LINE;
				end else if (c == CH_STAR) begin
					lex_mode = MODE_BLOCK_STAR;
				end else begin
					kept_len = '0;
					keep_byte(CH_SLASH);
					word_step(c);
				end
			end
			MODE_LINE: begin
				if (c == CH_NUL) begin
					push_res(KIND_END_TEXT, '0);
					lex_mode = MODE_SKIP;
				end else if (c == CH_LF) begin
					lex_mode = MODE_SKIP;
				end
			end
			MODE_BLOCK, MODE_BLOCK_STAR: begin
				if (c == CH_NUL) begin
					push_res(KIND_END_TEXT, '0);
					lex_mode = MODE_SKIP;
				end else if (c == CH_STAR) begin
					lex_mode = MODE_BLOCK_STAR;
				end else if (c == CH_SLASH && lex_mode == MODE_BLOCK_STAR) begin
					lex_mode = MODE_SKIP;
				end else begin
					lex_mode = MODE_BLOCK;
				end
			end
			MODE_QUOTED: begin
				if (c == CH_NUL) begin
					push_res(KIND_END_TOKEN, '0);
					push_res(KIND_END_TEXT, '0);
					lex_mode = MODE_SKIP;
					kept_len = '0;
				end else if (c == CH_QUOTE) begin
					push_res(KIND_END_TOKEN, '0);
					lex_mode = MODE_SKIP;
					kept_len = '0;
				end else begin
					keep_byte(c);
				end
			end
			MODE_WORD: word_step(c);
			default: begin
				kept_len = '0;
				if (c == CH_NUL) begin
					push_res(KIND_END_TEXT, '0);
					lex_mode = MODE_SKIP;
				end else if (c <= CH_SPACE) begin
					lex_mode = MODE_SKIP;
				end else if (c == CH_SLASH) begin
					lex_mode = MODE_SLASH;
				end else if (c == CH_QUOTE) begin
					lex_mode = MODE_QUOTED;
				end else begin
					keep_byte(c);
					lex_mode = MODE_WORD;
				end
			end
		endcase
		if (tok_expect_q.size() > first)
			tok_expect_q[tok_expect_q.size() - 1].last = 1'b1;
	endtask

	// Text generation: directed bytes, then random well-formed pieces with some noise
	initial begin : text_gen
		logic [7:0] c;
		int         n;
		foreach (DIRECTED[i])
			text_q.push_back(DIRECTED[i]);
		while (text_q.size() < $size(DIRECTED) + RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0: repeat ($urandom_range(1, 3))
					text_q.push_back(8'($urandom_range(1, 32)));
				1: begin
					text_q.push_back(rand_word_start());
					repeat ($urandom_range(0, 5))
						text_q.push_back(rand_word_char());
				end
				2: begin
					text_q.push_back(rand_word_start());
					repeat ($urandom_range(0, 3))
						text_q.push_back(rand_word_char());
					text_q.push_back(CH_COMMA);
					repeat ($urandom_range(0, 3))
						text_q.push_back(rand_word_char());
				end
				3: begin
					text_q.push_back(CH_QUOTE);
					repeat ($urandom_range(0, 5)) begin
						c = 8'($urandom_range(1, 255));
						text_q.push_back((c == CH_QUOTE) ? 8'h27 : c);
					end
					text_q.push_back(CH_QUOTE);
				end
				4: begin
					text_q.push_back(CH_SLASH);
					text_q.push_back(CH_SLASH);
					repeat ($urandom_range(0, 5)) begin
						c = 8'($urandom_range(1, 255));
						text_q.push_back((c == CH_LF) ? 8'h4C : c);
					end
					text_q.push_back(CH_LF);
				end
				5: begin
					text_q.push_back(CH_SLASH);
					text_q.push_back(CH_STAR);
					repeat ($urandom_range(0, 6)) begin
						n = $urandom_range(3);
						text_q.push_back((n == 0) ? CH_STAR : 8'($urandom_range(1, 255)));
					end
					text_q.push_back(CH_STAR);
					text_q.push_back(CH_SLASH);
				end
				6: begin
					text_q.push_back(CH_SLASH);
					c = rand_word_char();
					text_q.push_back((c == CH_SLASH || c == CH_STAR) ? 8'h6B : c);
				end
				7: text_q.push_back(CH_NUL);
				8: repeat ($urandom_range(1, 3))
					text_q.push_back(8'($urandom));
				default: begin
					text_q.push_back(CH_SLASH);
					text_q.push_back(CH_STAR);
					text_q.push_back(CH_SLASH);
				end
			endcase
		end
		total_bytes = text_q.size();
	end

	// Text byte driver; valid holds until the transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_valid <= 1'b0;
			send_byte  <= '0;
		end else begin
			if (send_valid && text_ch.ready) begin
				lex_byte(send_byte);
				bytes_done <= bytes_done + 1;
			end
			if (!send_valid || text_ch.ready) begin
				if (text_q.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
					send_valid <= 1'b1;
					send_byte  <= text_q.pop_front();
				end else begin
					send_valid <= 1'b0;
					send_byte  <= 8'($urandom);
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_mon
		tok_res_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (tok_ch.valid && res_ready) begin
				if (tok_expect_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, %s %0d byte 0x%h last %b",
						$time, "got kind", tok_ch.out_kind, tok_ch.token_byte,
						tok_ch.last);
				end else begin
					want = tok_expect_q.pop_front();
					if (tok_ch.out_kind !== want.kind || tok_ch.token_byte !== want.data ||
						tok_ch.last !== want.last) begin
						mismatches++;
						$display("%0t: result mismatch, expected kind %0d byte 0x%h last %b,",
							$time, want.kind, want.data, want.last,
							" got kind %0d byte 0x%h last %b",
							tok_ch.out_kind, tok_ch.token_byte, tok_ch.last);
					end
				end
			end
			res_ready <= ($urandom_range(99) >= idle_pct(1'b1));
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((send_valid && text_ch.ready) || (tok_ch.valid && res_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("comma_aware_text_tokenizer_top test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// End of run: all text sent, every prediction checked, then a short drain
	initial begin
		@(posedge arst_n);
		while (text_q.size() != 0 || send_valid || tok_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("comma_aware_text_tokenizer_top test passed");
		else
			$display("comma_aware_text_tokenizer_top test failed");
		$finish;
	end

endmodule
